/* rtl/core/fwu_pkg.sv */
// Shared types and constants of the firmware update receiver.
package fwu_pkg;

  localparam logic [31:0] IMAGE_BASE       = 32'd134234112;
  localparam logic [31:0] FLASH_LIMIT      = 32'd134283264;
  localparam logic [3:0]  RETRY_LIMIT      = 4'd10;
  localparam logic [7:0]  FULL_PIECE_BYTES = 8'd100;
  localparam logic [7:0]  HEADER_BYTES     = 8'd7;
  localparam logic [15:0] STATUS_PAYLOAD   = 16'hFF;
  localparam logic [7:0]  NODE_ID_RESET    = 8'd1;

  // Operation codes of a received item.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_DATA   = 3'd2;
  localparam logic [2:0] OP_STATUS = 3'd3;

  // Kinds of frame that the receiver sends.
  localparam logic SEND_REQUEST = 1'b0;
  localparam logic SEND_STATUS  = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_START,
    CMD_DATA,
    CMD_STATUS
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  port;
    logic [7:0]  id;
    logic [15:0] seq;
    logic [7:0]  count;
    logic        misaligned;
  } fwu_cmd_t;

endpackage

/* rtl/core/fwu_front.sv */
// Front end: decodes received items into commands for the queue.
module fwu_front
  import fwu_pkg::*;
(
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [2:0]           s_axis_tuser,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output fwu_cmd_t             cmd
);

  logic [7:0] count;

  // Payload count wraps modulo 256 for frames shorter than the header.
  assign count = s_axis_tdata[39:32] - HEADER_BYTES;

  assign s_axis_tready = cmd_ready;

  always_comb begin
    cmd.port       = s_axis_tdata[7:0];
    cmd.id         = s_axis_tdata[15:8];
    cmd.seq        = s_axis_tdata[31:16];
    cmd.count      = count;
    cmd.misaligned = (count[1:0] != 2'b00);
    cmd.kind       = CMD_TICK;
    cmd_valid      = s_axis_tvalid;
    unique case (s_axis_tuser)
      OP_TICK:   cmd.kind = CMD_TICK;
      OP_START:  cmd.kind = CMD_START;
      OP_DATA:   cmd.kind = CMD_DATA;
      OP_STATUS: cmd.kind = CMD_STATUS;
      default: begin
        // Other commands are taken and dropped here.
        cmd_valid = 1'b0;
      end
    endcase
  end

endmodule

/* rtl/core/fwu_queue.sv */
// Small command queue between the front end and the back end.
module fwu_queue
  import fwu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  fwu_cmd_t in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output fwu_cmd_t out_cmd
);

  fwu_cmd_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   fill;
  logic                push;
  logic                pop;

  assign in_ready  = (fill != QCNT_W'(QUEUE_DEPTH));
  assign out_valid = (fill != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill above depth");
`endif

endmodule

/* rtl/core/fwu_back.sv */
// Back end: protocol state, command execution and the result register.
module fwu_back
  import fwu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  fwu_cmd_t              cmd,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic [0:0]            m_axis_tuser
);

  logic [7:0]  node_id;
  logic [15:0] expected_sequence;
  logic [31:0] write_pointer;
  logic [3:0]  retry_count;
  logic [7:0]  peer_port;
  logic        erased_flag;

  logic [15:0] expected_sequence_next;
  logic [31:0] write_pointer_next;
  logic [3:0]  retry_count_next;
  logic [7:0]  peer_port_next;
  logic        erased_flag_next;

  logic        has_result;
  logic        send_valid;
  logic        send_kind;
  logic [7:0]  send_id;
  logic [15:0] send_payload;
  logic        erase_image;
  logic        write_valid;
  logic [31:0] write_address;
  logic [7:0]  write_length;
  logic        write_rejected;
  logic        boot_image;
  logic [32:0] piece_end;
  logic        pop;

  assign cmd_ready = !m_axis_tvalid || m_axis_tready;
  assign pop       = cmd_valid && cmd_ready;
  assign piece_end = {1'b0, write_pointer} + {25'd0, cmd.count};

  always_comb begin
    expected_sequence_next = expected_sequence;
    write_pointer_next     = write_pointer;
    retry_count_next       = retry_count;
    peer_port_next         = peer_port;
    erased_flag_next       = erased_flag;
    has_result             = 1'b0;
    send_valid             = 1'b0;
    send_kind              = SEND_REQUEST;
    send_id                = '0;
    send_payload           = '0;
    erase_image            = 1'b0;
    write_valid            = 1'b0;
    write_address          = '0;
    write_length           = '0;
    write_rejected         = 1'b0;
    boot_image             = 1'b0;
    unique case (cmd.kind)
      CMD_TICK: begin
        if (retry_count >= RETRY_LIMIT) begin
          retry_count_next = RETRY_LIMIT;
        end else begin
          retry_count_next = retry_count + 4'd1;
          has_result       = 1'b1;
          send_valid       = 1'b1;
          send_id          = node_id;
          send_payload     = expected_sequence;
        end
      end
      CMD_START: begin
        retry_count_next       = '0;
        expected_sequence_next = '0;
        write_pointer_next     = IMAGE_BASE;
        peer_port_next         = cmd.port;
        erase_image            = !erased_flag;
        erased_flag_next       = 1'b1;
        has_result             = 1'b1;
        send_valid             = 1'b1;
        send_id                = cmd.id;
      end
      CMD_DATA: begin
        if (cmd.seq == expected_sequence && cmd.port == peer_port) begin
          retry_count_next       = '0;
          write_rejected         = cmd.misaligned || (piece_end > {1'b0, FLASH_LIMIT});
          if (!write_rejected) begin
            erased_flag_next = 1'b0;
          end
          has_result             = 1'b1;
          write_valid            = 1'b1;
          write_address          = write_pointer;
          write_length           = cmd.count;
          write_pointer_next     = piece_end[31:0];
          expected_sequence_next = expected_sequence + 16'd1;
          if (cmd.count < FULL_PIECE_BYTES) begin
            boot_image = 1'b1;
          end else begin
            send_valid   = 1'b1;
            send_id      = node_id;
            send_payload = expected_sequence_next;
          end
        end
      end
      CMD_STATUS: begin
        has_result   = 1'b1;
        send_valid   = 1'b1;
        send_kind    = SEND_STATUS;
        send_id      = node_id;
        send_payload = STATUS_PAYLOAD;
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_id           <= NODE_ID_RESET;
      expected_sequence <= '0;
      write_pointer     <= IMAGE_BASE;
      retry_count       <= RETRY_LIMIT;
      peer_port         <= '0;
      erased_flag       <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        node_id <= cfg_wr_data;
      end
      if (pop) begin
        expected_sequence <= expected_sequence_next;
        write_pointer     <= write_pointer_next;
        retry_count       <= retry_count_next;
        peer_port         <= peer_port_next;
        erased_flag       <= erased_flag_next;
        m_axis_tvalid     <= has_result;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      m_axis_tdata <= {3'b000, boot_image, write_rejected, write_length, write_address,
                       write_valid, erase_image, send_payload, send_id,
                       (send_valid ? peer_port_next : 8'd0), send_valid};
      m_axis_tuser <= send_kind;
    end
  end

`ifndef SYNTHESIS
  a_retry_bounded: assert property (@(posedge clk) disable iff (rst)
    retry_count <= RETRY_LIMIT)
    else $error("retry count above limit");

  a_boot_with_write: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[76]) |-> (m_axis_tdata[34] && !m_axis_tdata[0]))
    else $error("boot request without a final write");

  a_erase_on_start: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[33]) |->
      (m_axis_tdata[0] && m_axis_tdata[32:17] == 16'd0 && !m_axis_tdata[34]))
    else $error("erase request outside a start reply");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(pop))
    else $error("result appeared without a command");
`endif

endmodule

/* rtl/core/firmware_update_receiver.sv */
// Top level of the firmware update receiver.
// An accepted item is registered in the queue and then loads the result
// register; a result stall on the output side can hold it in the queue.
// Throughput: one item per cycle while the queue has room; the back end retires
// one command per cycle while the result register is free or being drained.
// Reset (rst, synchronous): queue empty, no result pending, node id 1,
// sequence 0, write address at the image base, retry count at its limit.
module firmware_update_receiver
  import fwu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Node id register write.
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  // Received frames and idle ticks.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata, from bit 0: frame_port[7:0], frame_id[15:8], frame_sequence[31:16],
  // frame_length[39:32].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: operation[2:0].
  input  logic [2:0]            s_axis_tuser,
  // Results.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata, from bit 0: send_valid[0], send_port[8:1], send_id[16:9],
  // send_payload[32:17], erase_image[33], write_valid[34],
  // write_address[66:35], write_length[74:67], write_rejected[75],
  // boot_image[76], zero fill[79:77].
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: send_kind[0].
  output logic [0:0]            m_axis_tuser
);

  // The front end decodes each transfer into a command and drops unknown
  // operations. Commands wait in a short queue so that the input side keeps
  // moving while a result stalls on the output side.
  logic     front_valid;
  logic     front_ready;
  fwu_cmd_t front_cmd;
  logic     back_valid;
  logic     back_ready;
  fwu_cmd_t back_cmd;

  fwu_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (front_valid),
    .cmd_ready     (front_ready),
    .cmd           (front_cmd)
  );

  fwu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_cmd    (front_cmd),
    .out_valid (back_valid),
    .out_ready (back_ready),
    .out_cmd   (back_cmd)
  );

  // The back end owns all protocol state, so commands update it strictly in
  // arrival order; a command that yields no frame still retires.
  fwu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .cmd_valid     (back_valid),
    .cmd_ready     (back_ready),
    .cmd           (back_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench of the firmware update receiver.
`timescale 1ns / 100ps

module testbench;
  import fwu_pkg::*;

  // Cycles of input silence before a node id write.
  localparam int DRAIN_CYCLES = 6;
  // Cycles without any transfer after which the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;
  // Length of the long receiver hold-off that fills the block and stalls it.
  localparam int HOLD_CYCLES = 250;
  localparam int RANDOM_ITEMS = 750;
  // The first of the operation codes that the block ignores.
  localparam logic [2:0] OP_IGNORED_FIRST = OP_STATUS + 3'd1;
  localparam logic [2:0] OP_IGNORED_LAST = 3'd7;

  // One entry of the stimulus plan: a received frame, or a node id write that
  // waits until the block is idle.
  typedef struct {
    bit          is_cfg;
    logic [7:0]  cfg_value;
    logic [2:0]  op;
    logic [7:0]  port;
    logic [7:0]  id;
    logic [15:0] seq;
    logic [7:0]  len;
  } plan_entry_t;

  // Everything the receiver reports for one item.
  typedef struct {
    logic        send_valid;
    logic        send_kind;
    logic [7:0]  send_port;
    logic [7:0]  send_id;
    logic [15:0] send_payload;
    logic        erase_image;
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_length;
    logic        write_rejected;
    logic        boot_image;
  } receiver_output_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  logic [7:0]            cfg_wr_data = 8'd0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [2:0]            s_axis_tuser = 3'd0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;

  // Frames still to be offered, in order, and the outputs that the accepted
  // frames must still produce, oldest first.
  plan_entry_t      frame_plan[$];
  receiver_output_t outputs_due[$];

  // Shadow of the receiver's state, advanced at every accepted transfer.
  logic [7:0]  node_id_model;
  logic [15:0] seq_model;
  logic [31:0] ptr_model;
  logic [3:0]  retry_model;
  logic [7:0]  peer_model;
  logic        erased_model;

  // Generator-side view of the session, so that most data frames match.
  logic [15:0] plan_seq;
  logic [7:0]  plan_port;
  int          plan_items;

  int error_count = 0;
  int quiet_cycles = 0;
  bit sender_idle = 1'b0;

  always #5 clk = ~clk;

  firmware_update_receiver u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Advances the shadow state by one accepted frame and queues the output
  // that it must cause, if any.
  task automatic predict_receiver(input plan_entry_t f);
    receiver_output_t r;
    bit               has_output;
    logic [7:0]       count;
    r = '{default: '0};
    has_output = 1'b0;
    case (f.op)
      OP_TICK: begin
        // Ticks resend the current request until the retry budget is spent.
        if (retry_model >= RETRY_LIMIT) begin
          retry_model = RETRY_LIMIT;
        end else begin
          retry_model = retry_model + 4'd1;
          r.send_valid = 1'b1;
          r.send_kind = SEND_REQUEST;
          r.send_port = peer_model;
          r.send_id = node_id_model;
          r.send_payload = seq_model;
          has_output = 1'b1;
        end
      end
      OP_START: begin
        retry_model = 4'd0;
        seq_model = 16'd0;
        ptr_model = IMAGE_BASE;
        peer_model = f.port;
        // The erase is asked for only once until a good write lands.
        if (!erased_model) begin
          erased_model = 1'b1;
          r.erase_image = 1'b1;
        end
        r.send_valid = 1'b1;
        r.send_kind = SEND_REQUEST;
        r.send_port = peer_model;
        r.send_id = f.id;
        r.send_payload = 16'd0;
        has_output = 1'b1;
      end
      OP_DATA: begin
        // Frames for another piece or another peer leave everything alone.
        if (f.seq == seq_model && f.port == peer_model) begin
          retry_model = 4'd0;
          count = f.len - HEADER_BYTES;
          r.write_valid = 1'b1;
          r.write_address = ptr_model;
          r.write_length = count;
          // The end check is done one bit wider so that it cannot wrap.
          r.write_rejected = (count[1:0] != 2'd0) ||
                             (({1'b0, ptr_model} + 33'(count)) > {1'b0, FLASH_LIMIT});
          if (!r.write_rejected) erased_model = 1'b0;
          ptr_model = ptr_model + 32'(count);
          seq_model = seq_model + 16'd1;
          if (count < FULL_PIECE_BYTES) begin
            r.boot_image = 1'b1;
          end else begin
            r.send_valid = 1'b1;
            r.send_kind = SEND_REQUEST;
            r.send_port = peer_model;
            r.send_id = node_id_model;
            r.send_payload = seq_model;
          end
          has_output = 1'b1;
        end
      end
      OP_STATUS: begin
        r.send_valid = 1'b1;
        r.send_kind = SEND_STATUS;
        r.send_port = peer_model;
        r.send_id = node_id_model;
        r.send_payload = STATUS_PAYLOAD;
        has_output = 1'b1;
      end
      default: begin
      end
    endcase
    if (has_output) outputs_due.push_back(r);
  endtask

  function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Idle gaps: mostly none or short, now and then a long one.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic plan_frame(input logic [2:0] op, input logic [7:0] port,
                            input logic [7:0] id, input logic [15:0] seq,
                            input logic [7:0] len);
    plan_entry_t e;
    e = '{is_cfg: 1'b0, cfg_value: 8'd0, op: op, port: port, id: id, seq: seq, len: len};
    frame_plan.push_back(e);
    if (op == OP_START) begin
      plan_seq = 16'd0;
      plan_port = port;
    end else if (op == OP_DATA && seq == plan_seq && port == plan_port) begin
      plan_seq = plan_seq + 16'd1;
    end
    if (op <= OP_STATUS) plan_items++;
  endtask

  task automatic plan_node_id(input logic [7:0] value);
    plan_entry_t e;
    e = '{is_cfg: 1'b1, cfg_value: value, op: OP_TICK, port: 8'd0, id: 8'd0,
          seq: 16'd0, len: 8'd0};
    frame_plan.push_back(e);
  endtask

  // A data frame for the piece that is due, with its length given.
  task automatic plan_piece(input logic [7:0] len);
    plan_frame(OP_DATA, plan_port, 8'($urandom), plan_seq, len);
  endtask

  // One frame that disturbs a session without belonging to it.
  task automatic plan_noise();
    int          pick;
    logic [15:0] bad_seq;
    pick = $urandom_range(6);
    case (pick)
      0: repeat ($urandom_range(1, 12)) plan_frame(OP_TICK, 8'($urandom), 8'($urandom),
                                                   16'($urandom), 8'($urandom));
      1: plan_frame(OP_STATUS, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      2: plan_frame(3'($urandom_range(OP_IGNORED_FIRST, OP_IGNORED_LAST)), 8'($urandom),
                    8'($urandom), 16'($urandom), 8'($urandom));
      3: begin
        bad_seq = 16'($urandom);
        if (bad_seq == plan_seq) bad_seq = bad_seq + 16'd1;
        plan_frame(OP_DATA, plan_port, 8'($urandom), bad_seq, 8'($urandom));
      end
      4: plan_frame(OP_DATA, plan_port ^ 8'($urandom_range(1, 255)), 8'($urandom),
                    plan_seq, 8'($urandom));
      default: plan_frame(OP_DATA, 8'($urandom), 8'($urandom), 16'($urandom),
                          8'($urandom));
    endcase
  endtask

  // A transfer session: a start, then the pieces, with noise mixed in unless
  // the session is meant to run the image all the way to the flash end.
  task automatic plan_session(input int pieces, input bit full_only);
    int         count;
    logic [7:0] len;
    plan_frame(OP_START, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
    for (int i = 0; i < pieces; i++) begin
      if (!full_only && $urandom_range(99) < 20) plan_noise();
      if (full_only) begin
        len = 8'd255;
      end else if (i == pieces - 1 && $urandom_range(99) < 60) begin
        len = HEADER_BYTES + 8'($urandom_range(0, 99));
      end else if ($urandom_range(99) < 80) begin
        count = 4 * $urandom_range(25, 62);
        len = 8'(count) + HEADER_BYTES;
      end else begin
        len = 8'($urandom);
      end
      plan_piece(len);
    end
  endtask

  initial begin
    int session;
    node_id_model = NODE_ID_RESET;
    seq_model = 16'd0;
    ptr_model = IMAGE_BASE;
    retry_model = RETRY_LIMIT;
    peer_model = 8'd0;
    erased_model = 1'b0;
    plan_seq = 16'd0;
    plan_port = 8'd0;
    plan_items = 0;

    // Directed part. The lowest node id goes in first; a tick straight after
    // reset finds the retry budget already spent.
    plan_node_id(8'h00);
    plan_frame(OP_TICK, 8'h00, 8'h00, 16'h0000, 8'h00);
    plan_frame(OP_STATUS, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    plan_frame(OP_IGNORED_FIRST, 8'h12, 8'h34, 16'h0000, 8'h07);
    plan_frame(OP_IGNORED_LAST, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);
    // The first start asks for an erase, a second one right after does not.
    plan_frame(OP_START, 8'hA5, 8'h3C, 16'hFFFF, 8'h00);
    plan_frame(OP_START, 8'h5A, 8'hFF, 16'h1234, 8'hFF);
    // Ten resends, then silence.
    repeat (11) plan_frame(OP_TICK, 8'h00, 8'h00, 16'h0000, 8'h00);
    // Wrong sequence, then wrong port: both are dropped.
    plan_frame(OP_DATA, 8'h5A, 8'h00, 16'h0001, 8'hFF);
    plan_frame(OP_DATA, 8'hA5, 8'h00, 16'h0000, 8'hFF);
    plan_piece(8'd255);
    // A length below the header wraps to a large count.
    plan_piece(8'd3);
    // A count that is not a multiple of four is rejected and ends the image.
    plan_piece(8'd8);
    plan_node_id(8'hFF);
    plan_frame(OP_START, 8'h00, 8'h00, 16'h0000, 8'h00);
    plan_piece(8'd7);
    plan_piece(8'd0);
    // Exactly one full piece asks for more; one byte less asks to boot.
    plan_piece(HEADER_BYTES + FULL_PIECE_BYTES);
    plan_piece(HEADER_BYTES + FULL_PIECE_BYTES - 8'd1);
    plan_frame(OP_STATUS, 8'h00, 8'h00, 16'h0000, 8'h00);
    plan_frame(OP_TICK, 8'h00, 8'h00, 16'h0000, 8'h00);

    // Random part. One long session of full pieces runs past the flash end.
    plan_items = 0;
    session = 0;
    while (plan_items < RANDOM_ITEMS) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: plan_node_id(8'h00);
          1: plan_node_id(8'hFF);
          default: plan_node_id(8'($urandom));
        endcase
      end
      if (session == 3) plan_session(205, 1'b1);
      else plan_session($urandom_range(1, 20), 1'b0);
      if ($urandom_range(3) == 0) plan_noise();
      session++;
    end
    plan_node_id(NODE_ID_RESET);
    plan_frame(OP_STATUS, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // Sender. An offered frame stays on the bus until its transfer; a node id
  // write waits until every due output has come and the block has gone quiet.
  plan_entry_t held_frame;
  int          tx_gap = 0;
  int          tx_calm = 0;
  int          since_input = 0;

  always @(posedge clk) begin : sender
    plan_entry_t ent;
    logic        next_valid;
    logic        next_cfg;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      cfg_wr_en <= 1'b0;
    end else begin
      next_valid = s_axis_tvalid;
      next_cfg = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_receiver(held_frame);
        next_valid = 1'b0;
        since_input = 0;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = draw_gap();
          if ($urandom_range(39) == 0) tx_calm = $urandom_range(20, 80);
        end
      end else if (since_input < DRAIN_CYCLES) begin
        since_input++;
      end
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (frame_plan.size() != 0) begin
          ent = frame_plan[0];
          if (ent.is_cfg) begin
            if (outputs_due.size() == 0 && since_input >= DRAIN_CYCLES) begin
              next_cfg = 1'b1;
              cfg_wr_data <= ent.cfg_value;
              node_id_model = ent.cfg_value;
              void'(frame_plan.pop_front());
            end
          end else begin
            held_frame = ent;
            next_valid = 1'b1;
            s_axis_tdata <= {ent.len, ent.seq, ent.id, ent.port};
            s_axis_tuser <= ent.op;
            void'(frame_plan.pop_front());
          end
        end
      end
      if (!next_valid && frame_plan.size() == 0) sender_idle = 1'b1;
      s_axis_tvalid <= next_valid;
      cfg_wr_en <= next_cfg;
    end
  end

  // Receiver side. Each output transfer is checked against the oldest due
  // output; tready drops at random, and twice for a long hold-off.
  int rx_gap = 0;
  int rx_calm = 0;
  int hold_left = 0;
  int outputs_seen = 0;

  always @(posedge clk) begin : receiver
    receiver_output_t want;
    int               bad;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        outputs_seen++;
        if (outputs_due.size() == 0) begin
          $error("output transfer with no output due: tdata 0x%0h", m_axis_tdata);
          error_count++;
        end else begin
          want = outputs_due.pop_front();
          bad = 0;
          bad += field_mismatch("send_valid", 32'(want.send_valid), 32'(m_axis_tdata[0]));
          bad += field_mismatch("send_kind", 32'(want.send_kind), 32'(m_axis_tuser[0]));
          bad += field_mismatch("send_port", 32'(want.send_port), 32'(m_axis_tdata[8:1]));
          bad += field_mismatch("send_id", 32'(want.send_id), 32'(m_axis_tdata[16:9]));
          bad += field_mismatch("send_payload", 32'(want.send_payload),
                                32'(m_axis_tdata[32:17]));
          bad += field_mismatch("erase_image", 32'(want.erase_image), 32'(m_axis_tdata[33]));
          bad += field_mismatch("write_valid", 32'(want.write_valid), 32'(m_axis_tdata[34]));
          bad += field_mismatch("write_address", want.write_address, m_axis_tdata[66:35]);
          bad += field_mismatch("write_length", 32'(want.write_length),
                                32'(m_axis_tdata[74:67]));
          bad += field_mismatch("write_rejected", 32'(want.write_rejected),
                                32'(m_axis_tdata[75]));
          bad += field_mismatch("boot_image", 32'(want.boot_image), 32'(m_axis_tdata[76]));
          bad += field_mismatch("zero_fill", 32'd0, 32'(m_axis_tdata[79:77]));
          error_count += bad;
        end
        // Hold off long enough for the command queue to fill and push back.
        if (outputs_seen == 150 || outputs_seen == 480) begin
          hold_left = HOLD_CYCLES;
        end else if (rx_calm > 0) begin
          rx_calm--;
          rx_gap = 0;
        end else begin
          rx_gap = draw_gap();
          if ($urandom_range(39) == 0) rx_calm = $urandom_range(20, 80);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Cycles since the last transfer of any kind, for the watchdog.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // End of the run: all frames sent, all outputs seen, then a short drain in
  // which any stray output would still be caught.
  initial begin
    bit timed_out;
    timed_out = 1'b0;
    while (!(sender_idle && outputs_due.size() == 0) && !timed_out) begin
      @(posedge clk);
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (outputs_due.size() != 0) begin
      $error("%0d outputs never arrived", outputs_due.size());
      error_count++;
    end
    if (timed_out || error_count != 0) begin
      $display("testbench NOT OK");
    end else begin
      $display("testbench OK");
    end
    $finish;
  end

endmodule
